FILE: hdl/pue_pkg.sv
// Shared types, constants and the factorial table for the permutation unrank block.
package pue_pkg;

   localparam int MAX_ELEMENTS_DEFAULT = 8;
   localparam logic [3:0] ELEMENT_COUNT_RESET = 4'd8;
   localparam int REG_ELEMENT_COUNT = 0;

   typedef struct packed {
      logic [15:0] variant;
      logic [2:0]  word;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] element;
      logic       range_error;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_LAST,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
      logic write;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic last;
      logic out_free;
   } status_type;

   function automatic logic [31:0] fact_f(input int unsigned i);
      logic [31:0] f;
      case (i)
         0:       f = 32'd1;
         1:       f = 32'd1;
         2:       f = 32'd2;
         3:       f = 32'd6;
         4:       f = 32'd24;
         5:       f = 32'd120;
         6:       f = 32'd720;
         7:       f = 32'd5040;
         8:       f = 32'd40320;
         9:       f = 32'd362880;
         10:      f = 32'd3628800;
         default: f = 32'd0;
      endcase
      return f;
   endfunction

endpackage

FILE: hdl/pue_ctrl.sv
// Unrank sequencer: load, one step per position, final select, write; errors go to write.
module pue_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pue_pkg::status_type status,
   output pue_pkg::cmd_type    cmd
);
   import pue_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.err) state_in = ST_WRITE;
            else if (status.last) state_in = ST_LAST;
         end
         ST_LAST: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_RUN: begin
            cmd.step = !status.err;
         end
         ST_LAST: begin
            cmd.finish = 1'b1;
         end
         ST_WRITE: begin
            cmd.write = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.finish, cmd.write}))
      else $error("more than one datapath command at once");

endmodule

FILE: hdl/pue_datapath.sv
// Digit extraction, unused-value selection and output register for the unrank block.
module pue_datapath #(
   parameter int MAX_ELEMENTS = pue_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [3:0]               element_count,
   input  pue_pkg::req_payload_type req_payload,
   input  pue_pkg::cmd_type         cmd,
   output pue_pkg::status_type      status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pue_pkg::rsp_payload_type rsp_payload
);
   import pue_pkg::*;

   localparam int FW = $clog2(fact_f(MAX_ELEMENTS) + 1);
   localparam int CW = (FW > 16) ? FW : 16;
   localparam int NW = $clog2(MAX_ELEMENTS + 1);
   localparam int PW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int WW = (NW > 3) ? NW : 3;

   logic [FW-1:0]           k_ff, k_in;
   logic [PW-1:0]           p_ff, word_ff, digit_ff, value_ff;
   logic [MAX_ELEMENTS-1:0] used_ff;
   logic                    err_ff, have_digit_ff, rsp_valid_ff;
   rsp_payload_type         rsp_payload_ff;

   logic [NW-1:0] n_eff;
   logic [CW-1:0] total;
   logic          load_err;
   logic [PW-1:0] digit;
   logic [FW-1:0] sub;
   logic [PW-1:0] sel;
   logic          sel_found;
   logic          out_free;

   // effective element count, clamped to 1..MAX_ELEMENTS
   always_comb begin
      if (element_count == 4'd0) n_eff = NW'(1);
      else if (32'(element_count) > 32'(MAX_ELEMENTS)) n_eff = NW'(MAX_ELEMENTS);
      else n_eff = NW'(element_count);
      total = CW'(fact_f(32'(n_eff)));
      load_err = (CW'(req_payload.variant) >= total) ||
                 (WW'(req_payload.word) >= WW'(n_eff));
   end

   // digit = floor(k / p!) by comparing against the multiples 1..MAX_ELEMENTS-1 of p!
   always_comb begin
      logic [FW-1:0] thr;
      digit = '0;
      sub = '0;
      for (int d = 1; d < MAX_ELEMENTS; d++) begin
         thr = FW'(fact_f(32'(p_ff)) * 32'(d));
         if (k_ff >= thr) begin
            digit = PW'(d);
            sub = thr;
         end
      end
      k_in = k_ff - sub;
   end

   // pick the digit-th smallest value not yet used
   always_comb begin
      logic [PW:0] seen;
      seen = '0;
      sel_found = 1'b0;
      sel = '0;
      for (int v = 0; v < MAX_ELEMENTS; v++) begin
         if (!sel_found && !used_ff[v]) begin
            if (seen == {1'b0, digit_ff}) begin
               sel_found = 1'b1;
               sel = PW'(v);
            end else begin
               seen = seen + 1'b1;
            end
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         k_ff <= FW'(total - CW'(1) - CW'(req_payload.variant));
         p_ff <= PW'(n_eff - NW'(1));
         word_ff <= PW'(WW'(req_payload.word));
         used_ff <= '0;
         value_ff <= '0;
         err_ff <= load_err;
      end else begin
         if (cmd.step) begin
            k_ff <= k_in;
            digit_ff <= digit;
            p_ff <= p_ff - PW'(1);
         end
         if ((cmd.step && have_digit_ff) || cmd.finish) begin
            used_ff <= used_ff | (MAX_ELEMENTS'(1) << sel);
            value_ff <= sel;
         end
      end
      if (cmd.write) begin
         rsp_payload_ff.element <= err_ff ? 3'd0 : 3'(value_ff);
         rsp_payload_ff.range_error <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_digit_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) have_digit_ff <= 1'b0;
         else if (cmd.step) have_digit_ff <= 1'b1;
         if (cmd.write) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign status.err = err_ff;
   assign status.last = (p_ff == word_ff);
   assign status.out_free = out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_write_free: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> out_free)
      else $error("result written over a pending transaction");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.range_error) |-> (rsp_payload_ff.element == 3'd0))
      else $error("range error with nonzero element");

   a_sel_found: assert property (@(posedge clock) disable iff (reset)
      ((cmd.step && have_digit_ff) || cmd.finish) |-> sel_found)
      else $error("no unused value for digit");

endmodule

FILE: hdl/permutation_unrank_element.sv
// Top level: returns one element of permutation row variant, position word, of n elements.
// Sequence: load, run steps, final select, result write; a range error skips to the write.
// A new request is taken only in idle, after the write. One position per cycle,
// set by the digit compare against the multiples of p! and the unused-value select.
// Reset: synchronous, clears the sequencer and output valid; element_count returns to 8.
module permutation_unrank_element #(
   parameter int MAX_ELEMENTS = pue_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pue_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pue_pkg::rsp_payload_type rsp_payload,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import pue_pkg::*;

   logic [3:0] element_count_ff;
   logic       reg_hit;
   cmd_type    cmd;
   status_type status;

   // one register; paddr[2] is the register index
   assign reg_hit = (32'(paddr[2]) == REG_ELEMENT_COUNT);
   assign pready = 1'b1;
   assign prdata = reg_hit ? 32'(element_count_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         element_count_ff <= ELEMENT_COUNT_RESET;
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         element_count_ff <= pwdata[3:0];
      end
   end

   pue_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pue_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .element_count (element_count_ff),
      .req_payload   (req_payload),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload)
   );

endmodule
